>>> sv/c_escape_unquote_decoder_assert.svh
// Assertion macros for the string unescape decoder.
// Included by the top level; depends on nothing else.
`ifndef C_ESCAPE_UNQUOTE_DECODER_ASSERT_SVH
`define C_ESCAPE_UNQUOTE_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CUD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cud assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CUD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cud assertion failed");

`endif

>>> sv/cud_pkg.sv
// Shared types, constants and character helpers of the string unescape decoder.
// Used by every module of the block; depends on nothing.
`default_nettype none

package cud_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } cud_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       end_of_string;
    } cud_out_t;

    typedef struct packed {
        cud_out_t first;
        cud_out_t second;
        logic     two;
    } cud_rec_t;

    typedef struct packed {
        logic       we;
        logic [1:0] index;
        logic       data;
    } cud_cfg_wr_t;

    typedef struct packed {
        logic at_idle;
    } cud_front_stat_t;

    typedef struct packed {
        logic out_valid;
        logic pend_valid;
    } cud_back_stat_t;

    localparam logic [1:0] CFG_SIMPLE = 2'd0;
    localparam logic [1:0] CFG_OCTAL  = 2'd1;
    localparam logic [1:0] CFG_HEX    = 2'd2;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_V      = 8'h76;

    // Control code of a single letter escape, zero when the letter has none.
    function automatic logic [7:0] simple_code(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            CH_A:    r = 8'd7;
            CH_B:    r = 8'd8;
            CH_F:    r = 8'd12;
            CH_N:    r = 8'd10;
            CH_R:    r = 8'd13;
            CH_T:    r = 8'd9;
            CH_V:    r = 8'd11;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic is_octal(input logic [7:0] c);
        return c[7:3] == 5'b00110;
    endfunction

    // Bit 4 is the valid flag, bits 3:0 the digit value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        else
        begin
            r = 5'd0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/cud_front.sv
// Front end: holds the enables and escape state, classifies each accepted byte
// and builds a record of up to two results. Depends on cud_pkg.
`default_nettype none

module cud_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire cud_pkg::cud_cfg_wr_t      cfg,
    input  wire logic                      accept,
    input  wire cud_pkg::cud_in_t          item,
    output logic                           rec_push,
    output cud_pkg::cud_rec_t              rec,
    output cud_pkg::cud_front_stat_t       stat
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ESC,
        PH_OCT1,
        PH_OCT2,
        PH_HEXX,
        PH_HEX1,
        PH_STOP
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [5:0] value_reg, value_next;
    logic       simple_en_reg, octal_en_reg, hex_en_reg;

    logic [7:0] c;
    logic [7:0] scode;
    logic [4:0] hex;
    logic       oct;
    logic       idle_emit;
    phase_t     idle_phase;
    logic       release_now;
    logic [1:0] n;
    logic [7:0] e0, e1;

    always_comb
    begin
        c          = item.in_byte;
        scode      = cud_pkg::simple_code(c);
        hex        = cud_pkg::hex_digit(c);
        oct        = cud_pkg::is_octal(c);
        idle_emit  = (c != cud_pkg::CH_NUL) && (c != cud_pkg::CH_BSLASH) &&
                     (c != cud_pkg::CH_QUOTE);
        idle_phase = (c == cud_pkg::CH_NUL) ? PH_STOP :
                     (c == cud_pkg::CH_BSLASH) ? PH_ESC : PH_IDLE;

        phase_next  = phase_reg;
        value_next  = value_reg;
        release_now = 1'b0;
        n           = 2'd0;
        e0          = 8'd0;
        e1          = 8'd0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (idle_emit)
                begin
                    n  = 2'd1;
                    e0 = c;
                end
                phase_next = idle_phase;
            end
            PH_ESC:
            begin
                if (c == cud_pkg::CH_NUL)
                begin
                    phase_next = PH_STOP;
                end
                else if (simple_en_reg && scode != 8'd0)
                begin
                    n          = 2'd1;
                    e0         = scode;
                    phase_next = PH_IDLE;
                end
                else if (octal_en_reg && oct)
                begin
                    value_next = {3'd0, c[2:0]};
                    phase_next = PH_OCT1;
                end
                else if (hex_en_reg && c == cud_pkg::CH_X)
                begin
                    phase_next = PH_HEXX;
                end
                else
                begin
                    n          = 2'd1;
                    e0         = c;
                    phase_next = PH_IDLE;
                end
            end
            PH_OCT1:
            begin
                if (oct)
                begin
                    value_next = {value_reg[2:0], c[2:0]};
                    phase_next = PH_OCT2;
                end
                else
                begin
                    release_now = 1'b1;
                end
            end
            PH_OCT2:
            begin
                if (oct)
                begin
                    n          = 2'd1;
                    e0         = {value_reg[4:0], c[2:0]};
                    value_next = 6'd0;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    release_now = 1'b1;
                end
            end
            PH_HEXX:
            begin
                if (hex[4])
                begin
                    value_next = {2'd0, hex[3:0]};
                    phase_next = PH_HEX1;
                end
                else
                begin
                    phase_next = PH_STOP;
                end
            end
            PH_HEX1:
            begin
                if (hex[4])
                begin
                    n          = 2'd1;
                    e0         = {value_reg[3:0], hex[3:0]};
                    value_next = 6'd0;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    release_now = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_STOP;
            end
        endcase

        // The pending value goes out first, then the ending byte is decoded afresh.
        if (release_now)
        begin
            n          = 2'd1;
            e0         = {2'd0, value_reg};
            value_next = 6'd0;
            if (idle_emit)
            begin
                n  = 2'd2;
                e1 = c;
            end
            phase_next = idle_phase;
        end

        if (item.in_last)
        begin
            if (phase_next == PH_OCT1 || phase_next == PH_OCT2 || phase_next == PH_HEX1)
            begin
                if (n == 2'd0)
                begin
                    e0 = {2'd0, value_next};
                end
                else
                begin
                    e1 = {2'd0, value_next};
                end
                n = n + 2'd1;
            end
            phase_next = PH_IDLE;
            value_next = 6'd0;
        end

        rec.first.out_byte       = e0;
        rec.first.has_byte       = (n != 2'd0);
        rec.first.end_of_string  = item.in_last && (n != 2'd2);
        rec.second.out_byte      = e1;
        rec.second.has_byte      = 1'b1;
        rec.second.end_of_string = item.in_last;
        rec.two                  = (n == 2'd2);
        rec_push                 = accept && ((n != 2'd0) || item.in_last);
        stat.at_idle             = (phase_reg == PH_IDLE) && (value_reg == 6'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            value_reg     <= 6'd0;
            simple_en_reg <= 1'b1;
            octal_en_reg  <= 1'b1;
            hex_en_reg    <= 1'b1;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                value_reg <= value_next;
            end
            if (cfg.we)
            begin
                case (cfg.index)
                    cud_pkg::CFG_SIMPLE: simple_en_reg <= cfg.data;
                    cud_pkg::CFG_OCTAL:  octal_en_reg  <= cfg.data;
                    cud_pkg::CFG_HEX:    hex_en_reg    <= cfg.data;
                    default:             ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/cud_queue.sv
// Short record queue between the front and back ends of the decoder.
// Depends on cud_pkg for the record type.
`default_nettype none

module cud_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr,
    input  wire cud_pkg::cud_rec_t wdata,
    input  wire logic              rd,
    output cud_pkg::cud_rec_t      head,
    output logic                   full,
    output logic                   empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cud_pkg::cud_rec_t  mem [DEPTH];
    logic [PTR_W-1:0]   wptr_reg, rptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wptr_reg <= (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
            end
            if (rd)
            begin
                rptr_reg <= (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
            end
            if (wr && !rd)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (rd && !wr)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/cud_back.sv
// Back end: takes records from the queue and hands out their results one per
// request through an output register and a hold slot. Depends on cud_pkg.
`default_nettype none

module cud_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cud_pkg::cud_rec_t q_head,
    input  wire logic              q_empty,
    output logic                   q_pop,
    input  wire logic              pop,
    output logic                   empty,
    output cud_pkg::cud_out_t      out_data,
    output cud_pkg::cud_back_stat_t stat
);

    logic              out_valid_reg;
    logic              pend_valid_reg;
    cud_pkg::cud_out_t out_reg;
    cud_pkg::cud_out_t pend_reg;
    logic              slot_free;

    assign slot_free = !out_valid_reg || pop;
    assign q_pop     = slot_free && !pend_valid_reg && !q_empty;
    assign empty     = !out_valid_reg;
    assign out_data  = out_reg;
    assign stat      = '{out_valid: out_valid_reg, pend_valid: pend_valid_reg};

    always_ff @(posedge clk)
    begin
        if (slot_free)
        begin
            if (pend_valid_reg)
            begin
                out_reg <= pend_reg;
            end
            else if (!q_empty)
            begin
                out_reg  <= q_head.first;
                pend_reg <= q_head.second;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            if (pend_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else if (!q_empty)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= q_head.two;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/c_escape_unquote_decoder.sv
// C string unescape decoder: one byte per cycle while not full, up to two results each.
// A byte's first result goes through the record queue and the output register to the ports.
// Input rate is one byte per cycle while the QUEUE_DEPTH record queue has room; the
// output register gives one result per cycle while pop is high; two results go in turn.
// Reset clears the escape state to idle, sets all enables to one and empties the queue.
`default_nettype none

`include "c_escape_unquote_decoder_assert.svh"

module c_escape_unquote_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire cud_pkg::cud_in_t  in_data,
    output logic                   empty,
    input  wire logic              pop,
    output cud_pkg::cud_out_t      out_data,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic              cfg_data
);

    cud_pkg::cud_cfg_wr_t    cfg;
    cud_pkg::cud_rec_t       rec;
    cud_pkg::cud_rec_t       q_head;
    cud_pkg::cud_front_stat_t fr_stat;
    cud_pkg::cud_back_stat_t bk_stat;
    logic                    accept;
    logic                    rec_push;
    logic                    q_pop;
    logic                    q_empty;

    assign cfg    = '{we: cfg_we, index: cfg_index, data: cfg_data};
    assign accept = push && !full;

    cud_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .accept   (accept),
        .item     (in_data),
        .rec_push (rec_push),
        .rec      (rec),
        .stat     (fr_stat)
    );

    cud_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (rec_push),
        .wdata (rec),
        .rd    (q_pop),
        .head  (q_head),
        .full  (full),
        .empty (q_empty)
    );

    cud_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_head   (q_head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .out_data (out_data),
        .stat     (bk_stat)
    );

    `CUD_ASSERT_NOW(a_pend_needs_out, clk, rst_n, bk_stat.pend_valid, bk_stat.out_valid)
    `CUD_ASSERT_NOW(a_pop_not_empty, clk, rst_n, q_pop, !q_empty)
    `CUD_ASSERT_NEXT(a_last_to_idle, clk, rst_n, accept && in_data.in_last, fr_stat.at_idle)

endmodule

`default_nettype wire

>>> tb/sv/c_escape_unquote_decoder_check.sv
// Checker for the string unescape decoder: watches the request, result and register ports.
// Predicts the decoded bytes of every accepted request and compares each popped result.
// Depends on cud_pkg for the port types, register indexes and character codes.
module c_escape_unquote_decoder_check
    import cud_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  logic     full,
    input  cud_in_t  in_data,
    input  logic     empty,
    input  logic     pop,
    input  cud_out_t out_data,
    input  logic     cfg_we,
    input  logic [1:0] cfg_index,
    input  logic     cfg_data,
    output int       mismatch_count,
    output int       decoded_waiting
);

    localparam logic [7:0] DIGIT_ZERO  = "0";
    localparam logic [7:0] DIGIT_SEVEN = "7";
    localparam logic [7:0] DIGIT_NINE  = "9";
    localparam logic [7:0] UPPER_A     = "A";
    localparam logic [7:0] UPPER_F     = "F";

    typedef enum logic [2:0] {
        DEC_IDLE,
        DEC_ESCAPE,
        DEC_OCT_ONE,
        DEC_OCT_TWO,
        DEC_HEX_WAIT,
        DEC_HEX_ONE,
        DEC_HALTED
    } dec_phase_e;

    dec_phase_e dec_phase;
    logic [8:0] esc_value;
    logic       simple_on;
    logic       octal_on;
    logic       hex_on;
    cud_out_t   decoded_q[$];

    function automatic logic [7:0] control_code(input logic [7:0] c);
        case (c)
            CH_A:    return 8'd7;
            CH_B:    return 8'd8;
            CH_F:    return 8'd12;
            CH_N:    return 8'd10;
            CH_R:    return 8'd13;
            CH_T:    return 8'd9;
            CH_V:    return 8'd11;
            default: return 8'd0;
        endcase
    endfunction

    function automatic logic octal_char(input logic [7:0] c);
        return c >= DIGIT_ZERO && c <= DIGIT_SEVEN;
    endfunction

    function automatic int hex_value(input logic [7:0] c);
        if (c >= DIGIT_ZERO && c <= DIGIT_NINE)
        begin
            return int'(c - DIGIT_ZERO);
        end
        if (c >= UPPER_A && c <= UPPER_F)
        begin
            return int'(c - UPPER_A) + 10;
        end
        if (c >= CH_A && c <= CH_F)
        begin
            return int'(c - CH_A) + 10;
        end
        return -1;
    endfunction

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic unescape_byte(input logic [7:0] c, input logic last);
        logic [7:0] made[$];
        logic       plain;
        logic       release_held;
        int         h;
        cud_out_t   r;
        plain = 1'b0;
        release_held = 1'b0;
        h = hex_value(c);
        case (dec_phase)
            DEC_IDLE:
            begin
                plain = 1'b1;
            end
            DEC_ESCAPE:
            begin
                if (c == CH_NUL)
                begin
                    dec_phase = DEC_HALTED;
                end
                else if (simple_on && control_code(c) != 8'd0)
                begin
                    made.push_back(control_code(c));
                    dec_phase = DEC_IDLE;
                end
                else if (octal_on && octal_char(c))
                begin
                    esc_value = {6'd0, c[2:0]};
                    dec_phase = DEC_OCT_ONE;
                end
                else if (hex_on && c == CH_X)
                begin
                    dec_phase = DEC_HEX_WAIT;
                end
                else
                begin
                    made.push_back(c);
                    dec_phase = DEC_IDLE;
                end
            end
            DEC_OCT_ONE:
            begin
                if (octal_char(c))
                begin
                    esc_value = {esc_value[5:0], c[2:0]};
                    dec_phase = DEC_OCT_TWO;
                end
                else
                begin
                    release_held = 1'b1;
                end
            end
            DEC_OCT_TWO:
            begin
                if (octal_char(c))
                begin
                    made.push_back({esc_value[4:0], c[2:0]});
                    esc_value = '0;
                    dec_phase = DEC_IDLE;
                end
                else
                begin
                    release_held = 1'b1;
                end
            end
            DEC_HEX_WAIT:
            begin
                if (h < 0)
                begin
                    dec_phase = DEC_HALTED;
                end
                else
                begin
                    esc_value = 9'(h);
                    dec_phase = DEC_HEX_ONE;
                end
            end
            DEC_HEX_ONE:
            begin
                if (h >= 0)
                begin
                    made.push_back({esc_value[3:0], 4'(h)});
                    esc_value = '0;
                    dec_phase = DEC_IDLE;
                end
                else
                begin
                    release_held = 1'b1;
                end
            end
            default:
            begin
                dec_phase = DEC_HALTED;
            end
        endcase
        if (release_held)
        begin
            made.push_back(esc_value[7:0]);
            esc_value = '0;
            plain = 1'b1;
        end
        if (plain)
        begin
            if (c == CH_NUL)
            begin
                dec_phase = DEC_HALTED;
            end
            else if (c == CH_BSLASH)
            begin
                dec_phase = DEC_ESCAPE;
            end
            else
            begin
                dec_phase = DEC_IDLE;
                if (c != CH_QUOTE)
                begin
                    made.push_back(c);
                end
            end
        end
        if (last)
        begin
            if (dec_phase inside {DEC_OCT_ONE, DEC_OCT_TWO, DEC_HEX_ONE})
            begin
                made.push_back(esc_value[7:0]);
            end
            dec_phase = DEC_IDLE;
            esc_value = '0;
        end
        foreach (made[i])
        begin
            r.out_byte = made[i];
            r.has_byte = 1'b1;
            r.end_of_string = last && (i == made.size() - 1);
            decoded_q.push_back(r);
        end
        if (last && made.size() == 0)
        begin
            r.out_byte = 8'd0;
            r.has_byte = 1'b0;
            r.end_of_string = 1'b1;
            decoded_q.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cud_out_t want;
        if (!rst_n)
        begin
            dec_phase = DEC_IDLE;
            esc_value = '0;
            simple_on = 1'b1;
            octal_on = 1'b1;
            hex_on = 1'b1;
            decoded_q.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SIMPLE: simple_on = cfg_data;
                    CFG_OCTAL:  octal_on = cfg_data;
                    CFG_HEX:    hex_on = cfg_data;
                    default:    ;
                endcase
            end
            if (push && !full)
            begin
                unescape_byte(in_data.in_byte, in_data.in_last);
            end
            if (pop && !empty)
            begin
                if (decoded_q.size() == 0)
                begin
                    report($sformatf("result %p with no request waiting", out_data));
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (out_data.out_byte !== want.out_byte)
                    begin
                        report($sformatf("out_byte %h, expected %h",
                                         out_data.out_byte, want.out_byte));
                    end
                    if (out_data.has_byte !== want.has_byte)
                    begin
                        report($sformatf("has_byte %b, expected %b",
                                         out_data.has_byte, want.has_byte));
                    end
                    if (out_data.end_of_string !== want.end_of_string)
                    begin
                        report($sformatf("end_of_string %b, expected %b",
                                         out_data.end_of_string, want.end_of_string));
                    end
                end
            end
        end
        decoded_waiting = decoded_q.size();
    end

endmodule

>>> tb/sv/c_escape_unquote_decoder_test.sv
// Top of the string unescape decoder testbench: clock, reset, register writes and requests.
// Drives directed and random strings under three idling patterns; the checker judges results.
// Depends on cud_pkg, c_escape_unquote_decoder and c_escape_unquote_decoder_check.
module c_escape_unquote_decoder_test;
    import cud_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    localparam int         CYCLE_LIMIT   = 300000;
    localparam int         PHASE_ITEMS   = 158;
    localparam logic [7:0] DIGIT_ZERO    = "0";
    localparam int         SEND_IDLE[3]  = '{34, 68, 0};
    localparam int         RECV_IDLE[3]  = '{68, 34, 0};
    localparam logic [2:0] ENABLE_SETS[6] = '{3'b000, 3'b101, 3'b010, 3'b111, 3'b110, 3'b011};

    logic       clk;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    cud_in_t    in_data = '0;
    logic       pop = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_SIMPLE;
    logic       cfg_data = 1'b0;
    logic       full;
    logic       empty;
    cud_out_t   out_data;

    int    mismatch_count;
    int    decoded_waiting;
    int    cycle_count = 0;
    int    items_sent = 0;
    int    send_idle = 0;
    int    recv_idle = 0;
    string esc_letters = "abfnrtv";
    string hex_chars = "0123456789abcdefABCDEF";

    c_escape_unquote_decoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_data   (in_data),
        .empty     (empty),
        .pop       (pop),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    c_escape_unquote_decoder_check i_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .in_data         (in_data),
        .empty           (empty),
        .pop             (pop),
        .out_data        (out_data),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .decoded_waiting (decoded_waiting)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        pop <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_request(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        in_data <= '{in_byte: b, in_last: last};
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic send_string(input byte_q_t text);
        foreach (text[i])
        begin
            send_request(text[i], i == text.size() - 1);
        end
    endtask

    function automatic byte_q_t make_string();
        byte_q_t s;
        int      r;
        repeat ($urandom_range(1, 6))
        begin
            r = $urandom_range(99);
            if (r < 33)
            begin
                s.push_back(8'($urandom_range(32, 126)));
            end
            else if (r < 43)
            begin
                s.push_back(8'($urandom_range(255)));
            end
            else if (r < 46)
            begin
                s.push_back(CH_NUL);
            end
            else if (r < 50)
            begin
                s.push_back(CH_QUOTE);
            end
            else
            begin
                s.push_back(CH_BSLASH);
                if (r < 64)
                begin
                    s.push_back(esc_letters[$urandom_range(6)]);
                end
                else if (r < 80)
                begin
                    repeat ($urandom_range(1, 3))
                    begin
                        s.push_back(DIGIT_ZERO + 8'($urandom_range(7)));
                    end
                end
                else if (r < 93)
                begin
                    s.push_back(CH_X);
                    repeat ($urandom_range(2))
                    begin
                        s.push_back(hex_chars[$urandom_range(21)]);
                    end
                end
                else
                begin
                    s.push_back(8'($urandom_range(255)));
                end
            end
        end
        if ($urandom_range(9) == 0)
        begin
            s.push_back(CH_BSLASH);
        end
        return s;
    endfunction

    task automatic write_enables(input logic [2:0] en);
        cfg_we <= 1'b1;
        cfg_index <= CFG_SIMPLE;
        cfg_data <= en[2];
        @(posedge clk);
        cfg_index <= CFG_OCTAL;
        cfg_data <= en[1];
        @(posedge clk);
        cfg_index <= CFG_HEX;
        cfg_data <= en[0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        push <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (decoded_waiting != 0);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        int phase_end;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_enables(3'b111);
        send_idle = SEND_IDLE[0];
        recv_idle = RECV_IDLE[0];

        send_string({8'hFF, CH_QUOTE, CH_BSLASH, CH_N, CH_BSLASH, "7", "Z",
                     CH_BSLASH, "7", "7", "7", CH_BSLASH, CH_X, "F", "g",
                     CH_BSLASH, CH_X, "z", "A"});
        send_string({CH_BSLASH, "1"});
        send_string({CH_BSLASH});
        send_string({CH_NUL, 8'h01});
        send_string({CH_BSLASH, CH_NUL, "B"});
        send_string({CH_BSLASH, "q", CH_BSLASH, CH_QUOTE, CH_BSLASH, CH_X, "a"});

        for (int p = 0; p < 6; p++)
        begin
            drain();
            write_enables(ENABLE_SETS[p]);
            send_idle = SEND_IDLE[p / 2];
            recv_idle = RECV_IDLE[p / 2];
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                send_string(make_string());
            end
        end
        drain();
        repeat (12) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
